// File: hw/rtl/atsa_pkg.sv
// ----------------------------------------------------------------------------
// atsa_pkg
// shared constants for the aging timeslice arbiter: widths, register
// indexes and reset values of the configuration registers
// ----------------------------------------------------------------------------
`default_nettype none

package atsa_pkg;

  localparam int NUM_REQUESTERS_DEF = 256;

  localparam int TIMER_W = 15;
  localparam int STEP_W  = 8;
  localparam int CODE_W  = 8;
  localparam int IDX_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRANT_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_STEP       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_STEP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_ACTION_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_GOAL_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_GOAL_HIGH   = 3'd5;

  localparam logic [TIMER_W-1:0] RST_GRANT_THRESHOLD   = 15'd15;
  localparam logic [STEP_W-1:0]  RST_NORMAL_STEP       = 8'd1;
  localparam logic [STEP_W-1:0]  RST_BOOST_STEP        = 8'd3;
  localparam logic [CODE_W-1:0]  RST_BOOST_ACTION_CODE = 8'd10;
  localparam logic [CODE_W-1:0]  RST_BOOST_GOAL_LOW    = 8'd2;
  localparam logic [CODE_W-1:0]  RST_BOOST_GOAL_HIGH   = 8'd5;

endpackage

`default_nettype wire

// File: hw/rtl/aging_timeslice_arbiter_top.sv
// ----------------------------------------------------------------------------
// aging_timeslice_arbiter_top
// throughput: one request per cycle while out_stall is low, set by the
//   single timer ram read port feeding one aging stage, with forwarding
//   of the previous write
// reset: synchronous; the timer store reads as zero at once through per-entry
//   valid bits, so there is no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module aging_timeslice_arbiter_top
  import atsa_pkg::*;
#(
  parameter int NUM_REQUESTERS = NUM_REQUESTERS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  req_type,
  input  wire logic [IDX_W-1:0]      requester_index,
  input  wire logic [CODE_W-1:0]     action_code,
  input  wire logic [CODE_W-1:0]     sub_goal,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       granted,
  output logic      [TIMER_W-1:0]    timer_value
);

  localparam int REACH = 1 << IDX_W;
  localparam int DEPTH = (NUM_REQUESTERS < REACH) ? NUM_REQUESTERS : REACH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [TIMER_W-1:0] grant_threshold;
  logic [STEP_W-1:0]  normal_step;
  logic [STEP_W-1:0]  boost_step;
  logic [CODE_W-1:0]  boost_action_code;
  logic [CODE_W-1:0]  boost_goal_low;
  logic [CODE_W-1:0]  boost_goal_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      grant_threshold   <= RST_GRANT_THRESHOLD;
      normal_step       <= RST_NORMAL_STEP;
      boost_step        <= RST_BOOST_STEP;
      boost_action_code <= RST_BOOST_ACTION_CODE;
      boost_goal_low    <= RST_BOOST_GOAL_LOW;
      boost_goal_high   <= RST_BOOST_GOAL_HIGH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GRANT_THRESHOLD:   grant_threshold   <= cfg_data[TIMER_W-1:0];
        CFG_NORMAL_STEP:       normal_step       <= cfg_data[STEP_W-1:0];
        CFG_BOOST_STEP:        boost_step        <= cfg_data[STEP_W-1:0];
        CFG_BOOST_ACTION_CODE: boost_action_code <= cfg_data[CODE_W-1:0];
        CFG_BOOST_GOAL_LOW:    boost_goal_low    <= cfg_data[CODE_W-1:0];
        CFG_BOOST_GOAL_HIGH:   boost_goal_high   <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // aging stage registers
  logic               s1_valid;
  logic               s1_type;
  logic [IDX_W-1:0]   s1_idx;
  logic [CODE_W-1:0]  s1_act;
  logic [CODE_W-1:0]  s1_goal;
  logic               s1_fwd_hit;
  logic [TIMER_W-1:0] s1_fwd_val;

  // frame state
  logic               grant_given;
  logic [TIMER_W-1:0] last_highest;
  logic [TIMER_W-1:0] running_highest;
  logic [DEPTH-1:0]   tvalid;

  logic               in_accept;
  logic               s1_adv;
  logic               s1_go;
  logic               s1_inrange;
  logic               s1_wr;
  logic [AW-1:0]      s1_addr;
  logic [TIMER_W-1:0] ram_q;
  logic [TIMER_W-1:0] s1_cur;
  logic               s1_boost;
  logic [STEP_W-1:0]  s1_step;
  logic [TIMER_W:0]   s1_sum;
  logic [TIMER_W-1:0] s1_aged;
  logic               s1_grant;
  logic [TIMER_W-1:0] s1_new;

  assign s1_adv    = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign s1_go     = s1_valid && s1_adv;

  assign s1_inrange = (32'(s1_idx) < 32'(NUM_REQUESTERS));
  assign s1_wr      = !s1_type && s1_inrange;
  assign s1_addr    = s1_idx[AW-1:0];

  atsa_ram #(
    .WIDTH (TIMER_W),
    .DEPTH (DEPTH)
  ) u_timer_ram (
    .clk   (clk),
    .we    (s1_go && s1_wr),
    .waddr (s1_addr),
    .wdata (s1_new),
    .re    (in_accept),
    .raddr (requester_index[AW-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    if (s1_fwd_hit) begin
      s1_cur = s1_fwd_val;
    end else if (s1_inrange && tvalid[s1_addr]) begin
      s1_cur = ram_q;
    end else begin
      s1_cur = '0;
    end
    s1_boost = (s1_act == boost_action_code) && (s1_goal >= boost_goal_low) &&
               (s1_goal <= boost_goal_high);
    s1_step  = s1_boost ? boost_step : normal_step;
    s1_sum   = {1'b0, s1_cur} + {{(TIMER_W + 1 - STEP_W){1'b0}}, s1_step};
    s1_aged  = s1_sum[TIMER_W] ? TIMER_MAX : s1_sum[TIMER_W-1:0];
    s1_grant = s1_wr && !grant_given && (s1_aged > last_highest) &&
               (s1_aged > grant_threshold);
    s1_new   = s1_grant ? '0 : s1_aged;
  end

  // aging stage load, with forwarding of the write made at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1_fwd_hit <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid   <= 1'b1;
        s1_fwd_hit <= s1_go && s1_wr && (s1_idx == requester_index);
      end else if (s1_adv) begin
        s1_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_type    <= req_type;
      s1_idx     <= requester_index;
      s1_act     <= action_code;
      s1_goal    <= sub_goal;
      s1_fwd_val <= s1_new;
    end
  end

  // frame state and store valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      grant_given     <= 1'b0;
      last_highest    <= '0;
      running_highest <= '0;
      tvalid          <= '0;
    end else if (s1_go) begin
      if (s1_type) begin
        last_highest    <= running_highest;
        running_highest <= '0;
        grant_given     <= 1'b0;
      end else if (s1_inrange) begin
        tvalid[s1_addr] <= 1'b1;
        if (s1_grant) begin
          grant_given <= 1'b1;
        end else if (s1_aged > running_highest) begin
          running_highest <= s1_aged;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      granted     <= s1_grant;
      timer_value <= s1_wr ? s1_new : '0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/atsa_ram.sv
// ----------------------------------------------------------------------------
// atsa_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module atsa_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
